// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

	// table geometry
	localparam int MAX_TASKS_DEF = 8;
	localparam int MAX_RESULTS   = 8;

	// operation codes
	localparam logic [2:0] OP_CLEAR    = 3'd0;
	localparam logic [2:0] OP_ADD      = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_DELETE   = 3'd4;

	// result status codes
	localparam logic [2:0] ST_DONE       = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_BAD_SLOT   = 3'd2;
	localparam logic [2:0] ST_RUN        = 3'd3;
	localparam logic [2:0] ST_NONE_READY = 3'd4;

	// contents of one table slot
	typedef struct packed {
		logic [31:0] delay;
		logic [31:0] period;
		logic [7:0]  pending;
		logic [7:0]  handle;
	} task_t;

	// per-step control handed to the head unit
	typedef struct packed {
		logic [2:0] op;
		logic       in_use;      // slot at the head is below the task count
		logic       is_append;   // slot at the head is the first free one
		logic       after_slot;  // slot at the head is at or past the deleted one
		logic       last_step;   // final step of the walk
		logic       room;        // dispatch may still emit a word
	} walk_ctl_t;

endpackage

// ===== hw/rtl/pts_cell.sv =====
module pts_cell
	import pts_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  task_t d,
	output task_t q
);

	task_t slot_q;

	// take the neighbor's slot on every walk step
	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

// ===== hw/rtl/pts_head.sv =====
module pts_head
	import pts_pkg::*;
(
	input  walk_ctl_t  ctl,
	input  task_t      head,
	input  task_t      next,
	input  task_t      new_task,
	output task_t      push,
	output logic       emit
);

	// update of the slot leaving the head, fed back into the tail
	always_comb begin
		push = head;
		emit = 1'b0;
		unique case (ctl.op)
			OP_TICK: begin
				if (ctl.in_use) begin
					if (head.delay != 32'd0) begin
						push.delay = head.delay - 32'd1;
					end else begin
						push.delay = head.period;
						if (head.pending != 8'hFF) begin
							push.pending = head.pending + 8'd1;
						end
					end
				end
			end
			OP_DISPATCH: begin
				if (ctl.in_use && head.pending != 8'd0 && ctl.room) begin
					emit = 1'b1;
					push.pending = head.pending - 8'd1;
				end
			end
			OP_ADD: begin
				if (ctl.is_append) begin
					push = new_task;
				end
			end
			OP_DELETE: begin
				// from the deleted slot on, each slot takes its successor
				if (ctl.after_slot && !ctl.last_step) begin
					push = next;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/periodic_task_scheduler_table.sv =====
// channel | signals                                                   | direction
// in      | in_valid in_ready opcode task_handle initial_delay        | into block
//         | run_period slot_index                                     |
// out     | out_valid out_ready status run_handle run_slot last       | out of block
//
// A walking operation has three parts: accepting the word, MAX_TASKS steps of the slot
// ring past the head unit, and posting the final word. Clear, a full add, a bad delete
// and unknown codes skip the walk and go from accepting straight to posting.
// Reset clears the task count and the handshake state; slot contents are not reset.
// A dispatch walk pauses while a run word waits for a full output register.
// A new word is accepted while the previous result still waits at the output.
module periodic_task_scheduler_table
	import pts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  task_handle,
	input  logic [31:0] initial_delay,
	input  logic [31:0] run_period,
	input  logic [7:0]  slot_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  run_handle,
	output logic [2:0]  run_slot,
	output logic        last
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int RW = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] step_q;
	logic [RW-1:0] emitted_q;
	logic          held_valid_q;
	logic [7:0]    held_handle_q;
	logic [2:0]    held_slot_q;
	logic [2:0]    op_q;
	logic [2:0]    fin_q;
	logic [7:0]    slot_q;
	task_t         new_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [7:0]    run_handle_q;
	logic [2:0]    run_slot_q;
	logic          last_q;

	task_t         cells [MAX_TASKS];
	task_t         push;
	logic          emit;
	walk_ctl_t     ctl;

	logic          in_fire;
	logic          out_free;
	logic          need_push;
	logic          advance;
	logic          shift;
	logic          out_push;
	logic [2:0]    out_status;
	logic [7:0]    out_handle;
	logic [2:0]    out_slot;
	logic          out_last;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// step flags for the head unit
	assign ctl.op         = op_q;
	assign ctl.in_use     = CW'(step_q) < count_q;
	assign ctl.is_append  = CW'(step_q) == count_q;
	assign ctl.after_slot = 8'(step_q) >= slot_q;
	assign ctl.last_step  = step_q == SW'(MAX_TASKS - 1);
	assign ctl.room       = emitted_q < RW'(MAX_RESULTS);

	// a run word already held must leave before a new one is taken
	assign need_push = emit && held_valid_q;
	assign advance   = !need_push || out_free;
	assign shift     = (state_q == S_WALK) && advance;

	// ring of slots, the tail fed from the head unit
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		task_t d;
		if (i == MAX_TASKS - 1) begin : g_tail
			assign d = push;
		end else begin : g_mid
			assign d = cells[i+1];
		end
		pts_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (d),
			.q     (cells[i])
		);
	end

	pts_head u_head (
		.ctl      (ctl),
		.head     (cells[0]),
		.next     (cells[1 % MAX_TASKS]),
		.new_task (new_q),
		.push     (push),
		.emit     (emit)
	);

	// word posted to the output register
	always_comb begin
		out_push   = 1'b0;
		out_status = fin_q;
		out_handle = 8'd0;
		out_slot   = 3'd0;
		out_last   = 1'b1;
		if (state_q == S_WALK) begin
			if (need_push && out_free) begin
				out_push   = 1'b1;
				out_status = ST_RUN;
				out_handle = held_handle_q;
				out_slot   = held_slot_q;
				out_last   = 1'b0;
			end
		end else if (state_q == S_DONE && out_free) begin
			out_push = 1'b1;
			if (op_q == OP_DISPATCH) begin
				if (held_valid_q) begin
					out_status = ST_RUN;
					out_handle = held_handle_q;
					out_slot   = held_slot_q;
				end else begin
					out_status = ST_NONE_READY;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			emitted_q    <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						step_q       <= '0;
						emitted_q    <= '0;
						held_valid_q <= 1'b0;
						unique case (opcode)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							OP_ADD: begin
								state_q <= (count_q < CW'(MAX_TASKS)) ? S_WALK : S_DONE;
							end
							OP_TICK, OP_DISPATCH: begin
								state_q <= S_WALK;
							end
							OP_DELETE: begin
								state_q <= (slot_index < 8'(count_q)) ? S_WALK : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (advance) begin
						step_q <= step_q + SW'(1);
						if (emit) begin
							held_valid_q <= 1'b1;
							emitted_q    <= emitted_q + RW'(1);
						end
						if (ctl.last_step) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q      <= S_IDLE;
						held_valid_q <= 1'b0;
						if (op_q == OP_ADD && fin_q == ST_DONE) begin
							count_q <= count_q + CW'(1);
						end else if (op_q == OP_DELETE && fin_q == ST_DONE) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands of the current operation and output payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q           <= opcode;
			slot_q         <= slot_index;
			new_q.handle   <= task_handle;
			new_q.delay    <= initial_delay;
			new_q.period   <= run_period;
			new_q.pending  <= 8'd0;
			if (opcode == OP_ADD && count_q >= CW'(MAX_TASKS)) begin
				fin_q <= ST_FULL;
			end else if (opcode == OP_DELETE && slot_index >= 8'(count_q)) begin
				fin_q <= ST_BAD_SLOT;
			end else begin
				fin_q <= ST_DONE;
			end
		end
		if (shift && emit) begin
			held_handle_q <= cells[0].handle;
			held_slot_q   <= 3'(step_q);
		end
		if (out_push) begin
			status_q     <= out_status;
			run_handle_q <= out_handle;
			run_slot_q   <= out_slot;
			last_q       <= out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign run_handle = run_handle_q;
	assign run_slot   = run_slot_q;
	assign last       = last_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("task count beyond table size");

	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= RW'(MAX_RESULTS))
		else $error("too many run words in one dispatch");

	a_held_only_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> op_q == OP_DISPATCH)
		else $error("run word held outside a dispatch");

	a_run_only_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_status == ST_RUN |-> op_q == OP_DISPATCH)
		else $error("run word posted outside a dispatch");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK && advance && ctl.last_step |=> state_q == S_DONE)
		else $error("walk did not end after the last step");

endmodule
